FILE: hdl/gsd_pkg.sv
// shared types and constants for the gauge stream demultiplexer
`timescale 1ns / 1ps

package gsd_pkg;

  localparam int WORD_BITS = 32;
  localparam int STEP_W    = 17;
  localparam int CFG_AW    = 4;

  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_DATA  = 2'd1;
  localparam op_t OP_BEGIN = 2'd2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PENDING = 2'd0;
  localparam kind_t KIND_REC     = 2'd1;
  localparam kind_t KIND_DONE    = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SEL_STATION = 2'd0;
  localparam reg_idx_t REG_STATION_CNT = 2'd1;
  localparam reg_idx_t REG_STEP_CNT    = 2'd2;
  localparam reg_idx_t REG_GRID_VALID  = 2'd3;

  localparam logic [WORD_BITS-1:0] NODATA_BITS = 32'h42C6_0000;

  typedef struct packed {
    logic signed [STEP_W-1:0] first_step;
    logic signed [STEP_W-1:0] last_step;
  } gsd_entry_t;

endpackage

FILE: hdl/gsd_if.sv
// valid/ready channel interfaces for input items and samples
`timescale 1ns / 1ps

interface gsd_in_if import gsd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  op_t                      operation;
  logic [9:0]               station_index;
  logic signed [STEP_W-1:0] first_step;
  logic signed [STEP_W-1:0] last_step;
  logic [WORD_BITS-1:0]     data_word;

  modport source (output valid, operation, station_index, first_step, last_step, data_word,
                  input ready);
  modport sink   (input valid, operation, station_index, first_step, last_step, data_word,
                  output ready);
endinterface

interface gsd_out_if import gsd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [15:0]          step_index;
  logic [WORD_BITS-1:0] sample_bits;
  kind_t                sample_kind;
  logic                 last_sample;

  modport source (output valid, step_index, sample_bits, sample_kind, last_sample,
                  input ready);
  modport sink   (input valid, step_index, sample_bits, sample_kind, last_sample,
                  output ready);
endinterface

FILE: hdl/gsd_table.sv
// station first/last step table, one write port and one registered read port
`timescale 1ns / 1ps

module gsd_table import gsd_pkg::*; #(
  parameter int MAX_STATIONS = 1024,
  localparam int AW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  gsd_entry_t    wr_data,
  input  logic [AW-1:0] rd_addr,
  output gsd_entry_t    rd_data
);

  gsd_entry_t mem_r [MAX_STATIONS];
  gsd_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/gauge_stream_demultiplexer.sv
// top level: walks the station table per word and emits the selected station's samples
// load and begin items and words past the end of the series complete in the idle state;
//   a data word goes to check, then to idle when forced or finished, else walks the table
// a sample is offered from the output register in the cycle after its check; it may
//   wait there while the next word is taken, but the next sample waits until it is taken
// reset (rst_n low, synchronous) clears step counter, scan state, output valid and
//   config registers; the station table is not cleared and holds garbage until loaded
`timescale 1ns / 1ps

module gauge_stream_demultiplexer import gsd_pkg::*; #(
  parameter int MAX_STATIONS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  gsd_in_if.sink            in_if,
  gsd_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CHK  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  // configuration
  logic [9:0]  sel_r;
  logic [10:0] scnt_r;
  logic [15:0] steps_r;
  logic        gridv_r;
  logic        cfg_wr;

  // control
  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cur_r, cur_nxt;
  logic [10:0]       ptr_r, ptr_nxt;
  logic              expect_r, expect_nxt;
  logic              done_r, done_nxt;
  logic [10:0]       iss_r, iss_nxt;
  logic [10:0]       chk_r, chk_nxt;
  logic              pend_r, pend_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;

  // output register
  logic                 ov_r, ov_nxt;
  logic [15:0]          step_o_r;
  logic [WORD_BITS-1:0] bits_o_r;
  kind_t                kind_o_r;
  logic                 last_o_r;

  // table port
  logic          tbl_wr;
  logic [AW-1:0] tbl_raddr;
  gsd_entry_t    tbl_wdata;
  gsd_entry_t    ent;

  logic [10:0]              lim;
  logic [STEP_W-1:0]        cur_inc;
  logic signed [STEP_W-1:0] s;
  logic                     in_fire;
  logic                     out_busy;
  logic                     forced, fin, hit;
  logic                     chk_emit, load_out, do_end;
  logic [WORD_BITS-1:0]     chk_bits;
  kind_t                    chk_kind;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= '0;
      scnt_r  <= 11'd1;
      steps_r <= 16'd1;
      gridv_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_SEL_STATION: sel_r   <= pwdata[9:0];
        REG_STATION_CNT: scnt_r  <= pwdata[10:0];
        REG_STEP_CNT:    steps_r <= pwdata[15:0];
        REG_GRID_VALID:  gridv_r <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_SEL_STATION: prdata = {22'd0, sel_r};
      REG_STATION_CNT: prdata = {21'd0, scnt_r};
      REG_STEP_CNT:    prdata = {16'd0, steps_r};
      REG_GRID_VALID:  prdata = {31'd0, gridv_r};
    endcase
  end

  // stations at or beyond the table depth are never scanned
  assign lim = ({6'd0, scnt_r} < 17'(MAX_STATIONS)) ? scnt_r : 11'(MAX_STATIONS);

  assign in_fire  = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign out_busy = ov_r && !out_if.ready;

  // table access
  assign tbl_wr = in_fire && (in_if.operation == OP_LOAD) &&
                  ({7'd0, in_if.station_index} < 17'(MAX_STATIONS));
  assign tbl_wdata.first_step = in_if.first_step;
  assign tbl_wdata.last_step  = in_if.last_step;

  always_comb begin
    unique case (state_r)
      ST_SCAN: tbl_raddr = AW'(iss_r);
      default: tbl_raddr = AW'(sel_r);
    endcase
  end

  gsd_table #(
    .MAX_STATIONS(MAX_STATIONS)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (AW'(in_if.station_index)),
    .wr_data (tbl_wdata),
    .rd_addr (tbl_raddr),
    .rd_data (ent)
  );

  // one-based step number of the current step
  assign cur_inc = cur_r + 17'd1;
  assign s       = $signed(cur_inc);

  // in the check state ent holds the selected station's entry
  assign forced = !gridv_r || ({1'b0, sel_r} >= lim) || (ent.first_step == -17'sd1);
  assign fin    = (s >= ent.first_step) && (s > ent.last_step);
  // in the scan state ent holds the entry of chk_r
  assign hit    = pend_r && (s >= ent.first_step) && (s <= ent.last_step);

  always_comb begin
    if (forced) begin
      chk_emit = 1'b1;
      chk_bits = '0;
      chk_kind = KIND_PENDING;
    end else if (fin) begin
      chk_emit = 1'b1;
      chk_bits = NODATA_BITS;
      chk_kind = KIND_DONE;
    end else if (expect_r) begin
      // time record: a not-yet-started sample goes out here
      chk_emit = (s < ent.first_step);
      chk_bits = '0;
      chk_kind = KIND_PENDING;
    end else begin
      chk_emit = (ptr_r == {1'b0, sel_r});
      chk_bits = word_r;
      chk_kind = KIND_REC;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    ptr_nxt    = ptr_r;
    expect_nxt = expect_r;
    done_nxt   = done_r;
    iss_nxt    = iss_r;
    chk_nxt    = chk_r;
    pend_nxt   = pend_r;
    word_nxt   = word_r;
    load_out   = 1'b0;
    do_end     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_if.operation)
            OP_BEGIN: begin
              cur_nxt    = '0;
              ptr_nxt    = '0;
              expect_nxt = 1'b1;
              done_nxt   = 1'b0;
            end
            OP_DATA: begin
              if (done_r || (cur_r >= {1'b0, steps_r})) begin
                done_nxt = 1'b1;
              end else begin
                word_nxt  = in_if.data_word;
                state_nxt = ST_CHK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHK: begin
        if (!(chk_emit && out_busy)) begin
          load_out = chk_emit;
          pend_nxt = 1'b0;
          if (forced || fin) begin
            do_end    = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            if (expect_r) begin
              expect_nxt = 1'b0;
              iss_nxt    = '0;
            end else begin
              iss_nxt = ptr_r + 11'd1;
            end
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          ptr_nxt   = chk_r;
          pend_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else if (iss_r >= lim) begin
          // no further active station in this step
          pend_nxt  = 1'b0;
          do_end    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          chk_nxt  = iss_r;
          pend_nxt = 1'b1;
          iss_nxt  = iss_r + 11'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (do_end) begin
      cur_nxt    = cur_inc;
      ptr_nxt    = '0;
      expect_nxt = 1'b1;
      done_nxt   = (cur_inc >= {1'b0, steps_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cur_r    <= '0;
      ptr_r    <= '0;
      expect_r <= 1'b1;
      done_r   <= 1'b0;
      iss_r    <= '0;
      chk_r    <= '0;
      pend_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      ptr_r    <= ptr_nxt;
      expect_r <= expect_nxt;
      done_r   <= done_nxt;
      iss_r    <= iss_nxt;
      chk_r    <= chk_nxt;
      pend_r   <= pend_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_comb begin
    ov_nxt = ov_r && !out_if.ready;
    if (load_out) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (load_out) begin
      step_o_r <= cur_r[15:0];
      bits_o_r <= chk_bits;
      kind_o_r <= chk_kind;
      last_o_r <= (steps_r != 16'd0) && (cur_r == ({1'b0, steps_r} - 17'd1));
    end
  end

  assign out_if.valid       = ov_r;
  assign out_if.step_index  = step_o_r;
  assign out_if.sample_bits = bits_o_r;
  assign out_if.sample_kind = kind_o_r;
  assign out_if.last_sample = last_o_r;

endmodule

FILE: hdl/gsd_checker.sv
// port-level checks on the sample channel, bound to the top level
`timescale 1ns / 1ps

module gsd_checker import gsd_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_BITS-1:0] sample_bits,
  input kind_t                sample_kind
);

  // a stalled sample stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("sample dropped while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("sample valid after reset");

  a_pending_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (sample_kind == KIND_PENDING) |-> (sample_bits == '0))
    else $error("not-started sample is not zero");

  a_done_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (sample_kind == KIND_DONE) |-> (sample_bits == NODATA_BITS))
    else $error("finished sample is not the no-data pattern");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (sample_kind == KIND_PENDING) || (sample_kind == KIND_REC) ||
                  (sample_kind == KIND_DONE))
    else $error("sample kind out of range");

endmodule

bind gauge_stream_demultiplexer gsd_checker u_gsd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .sample_bits (out_if.sample_bits),
  .sample_kind (out_if.sample_kind)
);

FILE: bench/gauge_stream_demultiplexer_tb.sv
// testbench for the gauge stream demultiplexer: random blocks, config phases, sample checks
`timescale 1ns / 1ps

module gauge_stream_demultiplexer_tb;
  import gsd_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDLE_PCT    = 23;
  localparam int STALL_LIMIT = 6000;
  localparam int ITEM_GOAL   = 1550;
  localparam op_t OP_SPARE   = 2'd3;

  typedef struct {
    logic [15:0]          step;
    logic [WORD_BITS-1:0] bits;
    kind_t                kind;
    logic                 last;
  } sample_t;

  class gauge_series_model;
    logic signed [STEP_W-1:0] start_at[TABLE_DEPTH];
    logic signed [STEP_W-1:0] stop_at[TABLE_DEPTH];
    logic [STEP_W-1:0]        step_no;
    int unsigned              scan_at;
    bit                       await_time;
    bit                       series_done;
    logic [9:0]               sel;
    logic [10:0]              n_stations;
    logic [15:0]              n_steps;
    logic                     grid_ok;
    sample_t                  expected_samples[$];
    int                       errors;

    function new();
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        start_at[j] = '0;
        stop_at[j]  = '0;
      end
      step_no     = '0;
      scan_at     = 0;
      await_time  = 1'b1;
      series_done = 1'b0;
      sel         = '0;
      n_stations  = 11'd1;
      n_steps     = 16'd1;
      grid_ok     = 1'b1;
      errors      = 0;
    endfunction

    function int unsigned scan_limit();
      return (n_stations < TABLE_DEPTH) ? n_stations : TABLE_DEPTH;
    endfunction

    function int unsigned next_active(int unsigned from, int s);
      for (int unsigned j = from; j < scan_limit(); j++)
        if (s >= start_at[j] && s <= stop_at[j]) return j;
      return scan_limit();
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_SEL_STATION: sel        = v[9:0];
        REG_STATION_CNT: n_stations = v[10:0];
        REG_STEP_CNT:    n_steps    = v[15:0];
        REG_GRID_VALID:  grid_ok    = v[0];
        default: ;
      endcase
    endfunction

    function void put_sample(logic [WORD_BITS-1:0] bits, kind_t kind);
      sample_t e;
      e.step = step_no[15:0];
      e.bits = bits;
      e.kind = kind;
      e.last = (n_steps != 0) && (int'(step_no) == int'(n_steps) - 1);
      expected_samples.push_back(e);
    endfunction

    function void close_step();
      step_no    = step_no + 1'b1;
      scan_at    = 0;
      await_time = 1'b1;
      if (step_no >= n_steps) series_done = 1'b1;
    endfunction

    function void take_word(op_t op, logic [9:0] idx, logic signed [STEP_W-1:0] first,
                            logic signed [STEP_W-1:0] last, logic [WORD_BITS-1:0] word);
      int s;
      int st;
      int sp;
      if (op == OP_LOAD) begin
        start_at[idx] = first;
        stop_at[idx]  = last;
        return;
      end
      if (op == OP_BEGIN) begin
        step_no     = '0;
        scan_at     = 0;
        await_time  = 1'b1;
        series_done = 1'b0;
        return;
      end
      if (op != OP_DATA) return;
      if (series_done || step_no >= n_steps) begin
        series_done = 1'b1;
        return;
      end
      s = int'(step_no) + 1;
      // forced zero series: no parsing of the block at all
      if (!grid_ok || sel >= scan_limit() || start_at[sel] == -1) begin
        put_sample('0, KIND_PENDING);
        close_step();
        return;
      end
      st = start_at[sel];
      sp = stop_at[sel];
      if (s >= st && s > sp) begin
        put_sample(NODATA_BITS, KIND_DONE);
        close_step();
        return;
      end
      if (await_time) begin
        await_time = 1'b0;
        if (s < st) put_sample('0, KIND_PENDING);
        scan_at = next_active(0, s);
      end else begin
        if (scan_at == sel) put_sample(word, KIND_REC);
        scan_at = next_active(scan_at + 1, s);
      end
      if (scan_at >= scan_limit()) close_step();
    endfunction

    task report(string what);
      $display("%0t sample mismatch: %s", $time, what);
      errors++;
    endtask

    task check_sample(logic [15:0] step, logic [WORD_BITS-1:0] bits, kind_t kind,
                      logic last);
      sample_t e;
      if (expected_samples.size() == 0) begin
        report($sformatf("sample for step %0d with none expected", step));
        return;
      end
      e = expected_samples.pop_front();
      if (step !== e.step)
        report($sformatf("step_index %0d, expected %0d", step, e.step));
      if (bits !== e.bits)
        report($sformatf("step %0d sample_bits %h, expected %h", e.step, bits, e.bits));
      if (kind !== e.kind)
        report($sformatf("step %0d sample_kind %0d, expected %0d", e.step, kind, e.kind));
      if (last !== e.last)
        report($sformatf("step %0d last_sample %0b, expected %0b", e.step, last, e.last));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  gsd_in_if  in_bus();
  gsd_out_if out_bus();

  gauge_stream_demultiplexer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  gauge_series_model expected_series;
  bit                steady;
  int                items_sent;
  int                stall_count;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_bus.ready = steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      expected_series.check_sample(out_bus.step_index, out_bus.sample_bits,
                                   out_bus.sample_kind, out_bus.last_sample);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("gauge_stream_demultiplexer_tb NOT OK");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_item(op_t op, logic [9:0] idx, logic signed [STEP_W-1:0] first,
                           logic signed [STEP_W-1:0] last, logic [WORD_BITS-1:0] word);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid         = 1'b1;
    in_bus.operation     = op;
    in_bus.station_index = idx;
    in_bus.first_step    = first;
    in_bus.last_step     = last;
    in_bus.data_word     = word;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    expected_series.take_word(op, idx, first, last, word);
    if (op != OP_SPARE) items_sent++;
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    expected_series.set_reg(r, v);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // all samples out, then room for a table walk that emits nothing
  task automatic settle();
    while (expected_series.expected_samples.size() != 0) @(negedge clk);
    repeat (expected_series.scan_limit() + 24) @(negedge clk);
  endtask

  task automatic configure(int sel, int cnt, int steps, int grid);
    settle();
    write_reg(REG_SEL_STATION, sel);
    write_reg(REG_STATION_CNT, cnt);
    write_reg(REG_STEP_CNT, steps);
    write_reg(REG_GRID_VALID, grid);
  endtask

  function automatic logic signed [STEP_W-1:0] pick_first(int span);
    case ($urandom_range(0, 9))
      0: return -17'sd1;
      1: return STEP_W'($urandom);
      default: return STEP_W'($urandom_range(0, span + 2));
    endcase
  endfunction

  function automatic logic signed [STEP_W-1:0] pick_last(logic signed [STEP_W-1:0] first,
                                                          int span);
    if ($urandom_range(0, 9) < 7) return first + STEP_W'($urandom_range(0, span));
    return pick_first(span);
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic play_block(int cap, bit noisy);
    int words;
    logic signed [STEP_W-1:0] f;
    words = 0;
    send_item(OP_BEGIN, 10'($urandom), STEP_W'($urandom), STEP_W'($urandom), $urandom);
    while (!expected_series.series_done && expected_series.step_no < cap && words < 600) begin
      if (noisy && $urandom_range(99) < 6) begin
        case ($urandom_range(0, 3))
          0: send_item(OP_SPARE, 10'($urandom), STEP_W'($urandom), STEP_W'($urandom),
                       $urandom);
          1: begin
            // table rewrites only where every scanned entry is already loaded
            if (expected_series.scan_limit() <= 64) begin
              f = pick_first(expected_series.n_steps);
              send_item(OP_LOAD, 10'($urandom), f, pick_last(f, expected_series.n_steps),
                        $urandom);
            end
          end
          2: send_item(OP_BEGIN, 10'($urandom), STEP_W'($urandom), STEP_W'($urandom),
                       $urandom);
          default: send_item(OP_DATA, 10'($urandom), STEP_W'($urandom), STEP_W'($urandom),
                             pick_word());
        endcase
      end
      send_item(OP_DATA, 10'($urandom), STEP_W'($urandom), STEP_W'($urandom), pick_word());
      words++;
    end
  endtask

  task automatic run_phase(int sel, int cnt, int steps, int grid);
    int lim;
    logic signed [STEP_W-1:0] f;
    configure(sel, cnt, steps, grid);
    lim = expected_series.scan_limit();
    if (grid != 0 && sel < lim) begin
      if (lim <= 64) begin
        for (int j = 0; j < lim; j++) begin
          f = pick_first(steps);
          send_item(OP_LOAD, 10'(j), f, pick_last(f, steps), $urandom);
        end
      end else begin
        // wide table: keep the selected station silent so no unloaded entry is walked
        send_item(OP_LOAD, 10'(sel), -17'sd1, pick_first(steps), $urandom);
      end
    end else if ($urandom_range(0, 1) == 0) begin
      f = pick_first(steps);
      send_item(OP_LOAD, 10'($urandom), f, pick_last(f, steps), $urandom);
    end
    play_block((steps > 40) ? 30 : steps + 1, 1'b1);
    if ($urandom_range(0, 3) == 0)
      send_item(OP_DATA, 10'($urandom), STEP_W'($urandom), STEP_W'($urandom), pick_word());
  endtask

  initial begin
    int cnt;
    in_bus.valid         = 1'b0;
    in_bus.operation     = OP_LOAD;
    in_bus.station_index = '0;
    in_bus.first_step    = '0;
    in_bus.last_step     = '0;
    in_bus.data_word     = '0;
    out_bus.ready        = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    rst_n                = 1'b0;
    steady               = 1'b0;
    items_sent           = 0;
    expected_series      = new();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // one station, one step, then a surplus word after the series ends
    send_item(OP_LOAD, 10'd0, 17'sd1, 17'sd1, '0);
    play_block(2, 1'b0);
    send_item(OP_DATA, '0, '0, '0, '1);

    // pending, recorded, then finished samples on station 1
    configure(1, 3, 4, 1);
    send_item(OP_LOAD, 10'd0, 17'sd1, 17'sd4, '0);
    send_item(OP_LOAD, 10'd1, 17'sd2, 17'sd3, '0);
    send_item(OP_LOAD, 10'd2, -17'sd1, -17'sd1, '0);
    play_block(5, 1'b0);
    send_item(OP_SPARE, '1, '1, '1, '1);
    send_item(OP_LOAD, 10'h3FF, 17'sh0FFFF, -17'sd65536, '1);

    // outside the grid, then a station that never records
    configure(0, 3, 2, 0);
    play_block(3, 1'b0);
    configure(2, 3, 2, 1);
    play_block(3, 1'b0);

    while (items_sent < ITEM_GOAL) begin
      steady = (items_sent >= 700 && items_sent < 950);
      case ($urandom_range(0, 19))
        0: run_phase(1023, 1024, $urandom_range(1, 6), 0);
        1: run_phase($urandom_range(0, 1023), 2047, $urandom_range(1, 6), 1);
        2: run_phase($urandom_range(0, 1023), 0, $urandom_range(1, 6), 1);
        3: run_phase($urandom_range(0, 7), $urandom_range(1, 8), 0, 1);
        4: run_phase($urandom_range(0, 3), $urandom_range(1, 4), 65535, 1);
        5: run_phase($urandom_range(0, 7), $urandom_range(1, 8), $urandom_range(1, 6), 0);
        6: run_phase(1023, 1024, $urandom_range(1, 6), 1);
        7: begin
          cnt = $urandom_range(13, 64);
          run_phase($urandom_range(0, cnt - 1), cnt, $urandom_range(1, 4), 1);
        end
        default: begin
          cnt = $urandom_range(1, 12);
          if ($urandom_range(0, 6) == 0)
            run_phase($urandom_range(0, 1023), cnt, $urandom_range(1, 10), 1);
          else
            run_phase($urandom_range(0, cnt - 1), cnt, $urandom_range(1, 10), 1);
        end
      endcase
    end

    in_bus.valid = 1'b0;
    settle();
    if (expected_series.errors == 0) begin
      $display("gauge_stream_demultiplexer_tb OK");
    end else begin
      $display("gauge_stream_demultiplexer_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: gauge_stream_demultiplexer.f
hdl/gsd_pkg.sv
hdl/gsd_if.sv
hdl/gsd_table.sv
hdl/gauge_stream_demultiplexer.sv
hdl/gsd_checker.sv
bench/gauge_stream_demultiplexer_tb.sv
